// ===== rtl/cidr_network_match_table_top_assert.svh =====
// Assertion macros for the CIDR network match table.
`ifndef CIDR_NETWORK_MATCH_TABLE_TOP_ASSERT_SVH
`define CIDR_NETWORK_MATCH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CNMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define CNMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cnmt_pkg.sv =====
// ----------------------------------------------------------------------------
// cnmt_pkg
// Shared types, codes and helper functions for the CIDR network match table.
// ----------------------------------------------------------------------------
package cnmt_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;

    // Operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [ADDR_W-1:0] mask;
    } t_entry;

    // Prefix length to mask; lengths above 32 saturate to all ones.
    function automatic logic [ADDR_W-1:0] mask_for_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sh;
        sh = LEN_W'(ADDR_W) - len;
        if (len == '0) begin
            mask_for_length = '0;
        end else if (len >= LEN_W'(ADDR_W)) begin
            mask_for_length = '1;
        end else begin
            mask_for_length = {ADDR_W{1'b1}} << sh;
        end
    endfunction

    // Network byte order to host order.
    function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== rtl/cnmt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// cnmt_entry_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cnmt_entry_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  cnmt_pkg::t_entry    i_wr_entry,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output cnmt_pkg::t_entry    o_rd_entry
);
    import cnmt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_idx];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== rtl/cidr_network_match_table_top.sv =====
// ----------------------------------------------------------------------------
// cidr_network_match_table_top
// List of IPv4 CIDR networks with add and membership lookup commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a word is taken on a rising edge with start high and
//    busy low. i_op selects add (host-order i_address, i_prefix_length) or
//    lookup (i_address in network byte order, byte-swapped internally).
//  - Result channel: o_valid pulses for one cycle with o_match and o_status.
//    The receiver cannot stall; every command yields exactly one result word.
//  - Add: result in the cycle after acceptance; busy stays low, so adds may be
//    issued every cycle. A full table returns status full and stores nothing.
//  - Lookup: the entries sit in a single-port-read RAM with registered read
//    data and are scanned one per cycle, stopping at the first hit. On an
//    empty table the result comes in the cycle after acceptance; otherwise
//    it comes once the scan ends at a hit or at the last entry. busy is high
//    while the scan runs.
//  - Reset (synchronous, active low) clears the entry count and the control
//    state; the RAM contents are not cleared, as only entries below the count
//    are ever read.
// ----------------------------------------------------------------------------
module cidr_network_match_table_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [cnmt_pkg::ADDR_W-1:0] i_address,
    input  logic [cnmt_pkg::LEN_W-1:0]  i_prefix_length,
    output logic                        o_valid,
    output logic                        o_match,
    output logic                        o_status
);
    import cnmt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    logic [ADDR_W-1:0]  r_host,  n_host;
    logic               r_valid, n_valid;
    logic               r_match, n_match;
    logic               r_status, n_status;

    logic               accept;
    logic               table_full;
    logic               wr_en;
    t_entry             wr_entry;
    logic [ADDR_W-1:0]  add_mask;
    logic [IDX_W-1:0]   rd_idx;
    t_entry             rd_entry;
    logic               hit;
    logic               last_entry;

    assign accept     = start && (r_state == ST_IDLE);
    assign table_full = (r_count == CNT_W'(MAX_ENTRIES));
    assign add_mask   = mask_for_length(i_prefix_length);
    assign wr_entry   = '{network: i_address & add_mask, mask: add_mask};

    // Entry under test arrived from the RAM this cycle.
    assign hit        = ((r_host & rd_entry.mask) == rd_entry.network);
    assign last_entry = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    cnmt_entry_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_entry_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_idx   (r_count[IDX_W-1:0]),
        .i_wr_entry (wr_entry),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_host   <= n_host;
        r_match  <= n_match;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_host   = r_host;
        n_valid  = 1'b0;
        n_match  = r_match;
        n_status = r_status;
        wr_en    = 1'b0;
        rd_idx   = r_idx + IDX_W'(1);

        unique case (r_state)
            ST_IDLE: begin
                rd_idx = '0;
                if (accept) begin
                    if (i_op == OP_ADD) begin
                        n_valid = 1'b1;
                        n_match = 1'b0;
                        if (table_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_status = STATUS_OK;
                            wr_en    = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_host   = swap_bytes(i_address);
                        n_idx    = '0;
                        n_status = STATUS_OK;
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            n_match = 1'b0;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (hit || last_entry) begin
                    n_valid = 1'b1;
                    n_match = hit;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_match  = r_match;
    assign o_status = r_status;

`include "cidr_network_match_table_top_assert.svh"

    `CNMT_ASSERT_NEXT(a_add_result, i_clk, i_rst_n, accept && (i_op == OP_ADD), o_valid, "add without result")
    `CNMT_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ENTRIES), "entry count overflow")
    `CNMT_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result while scan still running")
    `CNMT_ASSERT_NOW(a_full_no_match, i_clk, i_rst_n, o_valid && o_status, !o_match, "full status with match")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CIDR network match table: add and lookup words
// are driven through the start/busy channel and every result word is checked
// against an in-bench model of the network list.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cnmt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;   // cycles with no word moving either way
    localparam int TAIL_CYCLES = 40;     // longer than the longest lookup
    localparam int RANDOM_WORDS = 550;

    // One pending command word; hold marks a pause until all results are in.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
        logic              calm;
        logic              hold;
    } t_cmd;

    // One expected result word.
    typedef struct packed {
        logic match;
        logic status;
    } t_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_op = OP_ADD;
    logic [ADDR_W-1:0] i_address = '0;
    logic [LEN_W-1:0]  i_prefix_length = '0;
    logic              o_valid;
    logic              o_match;
    logic              o_status;

    cidr_network_match_table_top #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .o_valid         (o_valid),
        .o_match         (o_match),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench model of the network list
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] known_net  [TABLE_DEPTH];
    logic [ADDR_W-1:0] known_mask [TABLE_DEPTH];
    int                known_fill = 0;
    t_outcome          results_due[$];

    int n_stored = 0;
    int n_refused = 0;
    int n_hits = 0;
    int n_misses = 0;

    // Words handed over / results taken. Both move by NBA so that either
    // clocked block sees the value from before the edge.
    int words_sent = 0;
    int words_seen = 0;
    int err_count = 0;

    // Prefix length to mask; anything past 32 means a host route.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] plen);
        if (plen == '0) begin
            return '0;
        end
        if (plen >= LEN_W'(ADDR_W)) begin
            return '1;
        end
        return {ADDR_W{1'b1}} << (ADDR_W - int'(plen));
    endfunction

    // Byte reversal; works both ways between wire and host order.
    function automatic logic [ADDR_W-1:0] flip_order(input logic [ADDR_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Apply one accepted word to the model and queue the result it owes.
    task automatic admit_word(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] plen);
        t_outcome          res;
        logic [ADDR_W-1:0] host;
        logic [ADDR_W-1:0] m;
        res.match  = 1'b0;
        res.status = STATUS_OK;
        if (op == OP_ADD) begin
            if (known_fill >= TABLE_DEPTH) begin
                res.status = STATUS_FULL;
                n_refused++;
            end else begin
                m = prefix_mask(plen);
                known_net[known_fill]  = addr & m;
                known_mask[known_fill] = m;
                known_fill++;
                n_stored++;
            end
        end else begin
            host = flip_order(addr);
            for (int k = 0; k < known_fill; k++) begin
                if ((host & known_mask[k]) == known_net[k]) begin
                    res.match = 1'b1;
                end
            end
            if (res.match) begin
                n_hits++;
            end else begin
                n_misses++;
            end
        end
        results_due.insert(results_due.size(), res);
    endtask

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("MISMATCH result %0d, %s: got %0b, want %0b", words_seen, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    t_cmd              cmd_q[$];
    logic [ADDR_W-1:0] plan_net[$];      // networks the queued adds will store
    logic [ADDR_W-1:0] plan_mask[$];
    logic              gen_calm = 1'b0;

    task automatic push_add(input logic [ADDR_W-1:0] host, input logic [LEN_W-1:0] plen);
        t_cmd c;
        c      = '0;
        c.op   = OP_ADD;
        c.addr = host;
        c.plen = plen;
        c.calm = gen_calm;
        cmd_q.insert(cmd_q.size(), c);
        if (plan_mask.size() < TABLE_DEPTH) begin
            plan_net.insert(plan_net.size(), host & prefix_mask(plen));
            plan_mask.insert(plan_mask.size(), prefix_mask(plen));
        end
    endtask

    // host is given in host order; the word carries it byte-swapped
    task automatic push_lookup(input logic [ADDR_W-1:0] host);
        t_cmd c;
        c      = '0;
        c.op   = OP_LOOKUP;
        c.addr = flip_order(host);
        c.plen = LEN_W'($urandom);
        c.calm = gen_calm;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic push_hold();
        t_cmd c;
        c      = '0;
        c.hold = 1'b1;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // Host address aimed at a planned network: inside it, or one masked bit
    // off it (often the boundary bit); now and then anywhere at all.
    function automatic logic [ADDR_W-1:0] aim_host();
        int                k;
        int                ones;
        logic [ADDR_W-1:0] h;
        logic [ADDR_W-1:0] m;
        if (plan_mask.size() == 0 || $urandom_range(0, 99) < 15) begin
            return $urandom;
        end
        k = $urandom_range(0, plan_mask.size() - 1);
        m = plan_mask[k];
        h = plan_net[k] | ($urandom & ~m);
        if (m != '0 && $urandom_range(0, 99) < 45) begin
            ones = $countones(m);
            if ($urandom_range(0, 1) == 1) begin
                h = h ^ (m & (~m + 1'b1));
            end else begin
                h = h ^ (32'h1 << $urandom_range(ADDR_W - ones, ADDR_W - 1));
            end
        end
        return h;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return LEN_W'($urandom_range(33, 63));   // saturates to /32
        end
        if (r < 30) begin
            return LEN_W'($urandom_range(2, 7));
        end
        return LEN_W'($urandom_range(8, 32));
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents words from cmd_q, idles at random, honours holds
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd word_out;
        logic taken;
        taken = 1'b0;
        if (i_rst_n) begin
            taken = start && !busy;
            if (taken) begin
                admit_word(i_op, i_address, i_prefix_length);
                words_sent <= words_sent + 1;
            end
            // a word still waiting on busy stays as it is
            if (!start || taken) begin
                if (cmd_q.size() == 0) begin
                    start <= 1'b0;
                end else if (cmd_q[0].hold) begin
                    start <= 1'b0;
                    if (!taken && words_seen == words_sent) begin
                        void'(cmd_q.pop_front());
                    end
                end else if (!cmd_q[0].calm && $urandom_range(0, 99) < 36) begin
                    start <= 1'b0;
                end else begin
                    word_out        = cmd_q.pop_front();
                    start           <= 1'b1;
                    i_op            <= word_out.op;
                    i_address       <= word_out.addr;
                    i_prefix_length <= word_out.plen;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed result against the oldest outstanding one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (words_seen >= words_sent) begin
                report_mismatch("result with nothing outstanding", o_match, 1'b0);
            end else begin
                want = results_due.pop_front();
                if (o_match !== want.match) begin
                    report_mismatch("match", o_match, want.match);
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                words_seen <= words_seen + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no word moving either way ends the run
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [ADDR_W-1:0] host;

        // Directed: lookups on an empty list.
        push_lookup(32'h0000_0000);
        push_lookup(32'hFFFF_FFFF);

        // Directed adds: usual prefixes, host route, saturated lengths,
        // /31 and a duplicate network.
        push_add(32'hC0A8_0164, 6'd24);
        push_add(32'hFFFF_FFFF, 6'd32);
        push_add(32'h0A00_0001, 6'd8);
        push_add(32'hAC10_FFFF, 6'd12);
        push_add(32'h0102_0304, 6'd33);
        push_add(32'h0506_0708, 6'd63);
        push_add(32'h6440_0001, 6'd31);
        push_add(32'hC0A8_01FF, 6'd24);   // same network as the first

        // Hits and near misses on each of them.
        push_lookup(32'hC0A8_01AB);
        push_lookup(32'hC0A8_0200);
        push_lookup(32'hFFFF_FFFE);
        push_lookup(32'h0AFF_FFFF);
        push_lookup(32'h0B00_0000);
        push_lookup(32'hAC1A_0000);
        push_lookup(32'hAC20_0000);
        push_lookup(32'h0102_0304);
        push_lookup(32'h0102_0305);
        push_lookup(32'h0506_0708);
        push_lookup(32'h6440_0000);
        push_lookup(32'h6440_0002);

        // Random: mostly aimed lookups, a few adds up to two short of full.
        // One stretch runs with no sender idling, with a full drain after it.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gen_calm = (n >= 180 && n < 300);
            if (n == 300) begin
                push_hold();
            end
            if ($urandom_range(0, 99) < 6 && plan_mask.size() < TABLE_DEPTH - 2) begin
                push_add($urandom, pick_length());
            end else begin
                push_lookup(aim_host());
            end
        end
        gen_calm = 1'b0;

        // Fill-up: a /1, any stragglers, then the match-all /0 last.
        push_hold();
        push_add(32'h8000_0000 | $urandom, 6'd1);
        while (plan_mask.size() < TABLE_DEPTH - 1) begin
            push_add($urandom, pick_length());
        end
        for (int n = 0; n < 16; n++) begin
            push_lookup(aim_host());
        end
        push_add($urandom, 6'd0);

        // Full list: adds refused with any length, lookups all hit.
        for (int n = 0; n < 64; n++) begin
            if ($urandom_range(0, 1) == 1) begin
                host = $urandom;
                push_add(host, LEN_W'($urandom));
            end else begin
                push_lookup($urandom);
            end
        end

        // Reset once, then let the driver run.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start || words_seen != words_sent) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d words: %0d adds stored, %0d refused on a full list,",
                 words_sent, n_stored, n_refused);
        $display("  %0d lookups hit and %0d missed; %0d result words checked.",
                 n_hits, n_misses, words_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
